>>> rtl/pet_pkg.sv
// Package for the path expression tokenizer: lexer modes, token kinds,
// error codes, result record and byte class functions.
// No dependencies; imported by the tokenizer and its checker.
package pet_pkg;

    localparam int POS_BITS_DEFAULT = 16;
    localparam int TOK_W            = 16;
    localparam int RES_DEPTH        = 4;
    localparam int RES_PTR_W        = $clog2(RES_DEPTH);
    localparam int RES_CNT_W        = $clog2(RES_DEPTH + 1);

    localparam logic [TOK_W-1:0] LEN_MAX = {TOK_W{1'b1}};

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'd0,
        MODE_SPACE    = 4'd1,
        MODE_IDENT    = 4'd2,
        MODE_NUM_INT  = 4'd3,
        MODE_NUM_FRAC = 4'd4,
        MODE_STR      = 4'd5,
        MODE_ESC      = 4'd6,
        MODE_HEX      = 4'd7,
        MODE_DISCARD  = 4'd8
    } mode_t;

    typedef enum logic [2:0] {
        KIND_SPACE  = 3'd0,
        KIND_IDENT  = 3'd1,
        KIND_NUMBER = 3'd2,
        KIND_STRING = 3'd3,
        KIND_PUNCT  = 3'd4,
        KIND_OTHER  = 3'd5,
        KIND_ERROR  = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNCLOSED  = 2'd1,
        ERR_ESC_END   = 2'd2,
        ERR_HEX_EMPTY = 2'd3
    } err_t;

    typedef struct packed {
        kind_t             kind;
        logic [TOK_W-1:0]  start;
        logic [TOK_W-1:0]  length;
        err_t              err;
        logic              run_last;
        logic              done;
    } res_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_id_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_UNDERSCORE) || c[7];
    endfunction

    function automatic logic is_id_cont(input logic [7:0] c);
        return is_id_start(c) || is_digit(c);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66))
            || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'h21) && (c <= 8'h7E) && !is_alpha(c) && !is_digit(c);
    endfunction

endpackage

>>> rtl/path_expression_tokenizer.sv
// Path expression tokenizer: byte stream in, tokens out.
// Depends on pet_pkg (modes, kinds, result record, byte classes).
//
// The tokenizer takes one byte per clock and reports tokens as kind, start
// offset and length. Whitespace runs, identifiers and numbers are reported
// when the first byte that cannot continue them arrives or when the stream
// ends (zero byte or a byte flagged last); punctuation and other single
// bytes on their own byte; strings on their closing quote. One byte causes
// up to two tokens. Each accepted byte is classified combinationally;
// the lexer state and the byte's tokens are registered on the edge that
// takes it, the tokens into a four-entry result queue. The input side
// stalls only while fewer than two queue entries are free, which at one
// token per byte on average keeps a steady rate of one byte per cycle as
// long as the consumer drains one token per cycle. After an error the rest
// of the stream up to its end marker is dropped without results. The
// skip_space register (write port cfg_valid/cfg_ready) hides whitespace
// tokens; write it only while the block is idle.
module path_expression_tokenizer #(
    parameter int POS_BITS = pet_pkg::POS_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write request
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     skip_space,
    // byte request
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               char_byte,
    input  logic                     last,
    // token request
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               token_kind,
    output logic [pet_pkg::TOK_W-1:0] token_start,
    output logic [pet_pkg::TOK_W-1:0] token_length,
    output logic [1:0]               error_code,
    output logic                     run_last,
    output logic                     stream_done
);
    import pet_pkg::*;

    // Lexer state
    mode_t                mode_reg,  mode_next;
    logic                 qd_reg,    qd_next;
    logic                 edc_reg,   edc_next;
    logic [POS_BITS-1:0]  begin_reg, begin_next;
    logic [POS_BITS-1:0]  pos_reg,   pos_next;
    logic [TOK_W-1:0]     cnt_reg,   cnt_next;
    logic                 skip_reg;

    // State after the byte itself, before any stream end
    mode_t                proc_mode;
    logic                 proc_qd;
    logic                 proc_edc;
    logic [POS_BITS-1:0]  proc_begin;
    logic [TOK_W-1:0]     proc_cnt;
    logic                 close_fire;
    logic                 start_fire;
    logic                 str_fire;
    logic                 hexerr_fire;

    logic                 accept;
    logic                 byte_live;
    logic                 end_now;
    logic [POS_BITS-1:0]  pos_inc;
    logic [POS_BITS-1:0]  end_pos;
    logic [TOK_W-1:0]     cnt_bump;
    mode_t                eff_mode;
    logic [7:0]           quote_ch;

    // Result candidates: pending close, byte's own token, stream end
    res_t                 res_a, res_b, res_c;
    logic                 va, vb, vc;
    res_t                 out0, out1;
    logic                 v0, v1;

    // Result queue
    res_t                 q_mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0] q_cnt_reg;
    logic                 pop;
    logic [1:0]           n_push;

    assign cfg_ready = 1'b1;
    assign in_ready  = (q_cnt_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign accept    = in_valid && in_ready;
    assign end_now   = (char_byte == CH_NUL) || last;
    assign byte_live = (char_byte != CH_NUL) && (mode_reg != MODE_DISCARD);
    assign pos_inc   = pos_reg + POS_BITS'(1);
    assign end_pos   = (char_byte == CH_NUL) ? pos_reg : pos_inc;
    assign cnt_bump  = (cnt_reg == LEN_MAX) ? cnt_reg : cnt_reg + TOK_W'(1);
    assign quote_ch  = qd_reg ? CH_DQUOTE : CH_SQUOTE;

    // A non-hex byte after one hex digit closes the escape and is then
    // handled as a plain string byte.
    assign eff_mode = (mode_reg == MODE_HEX && !is_hex(char_byte) && edc_reg)
                    ? MODE_STR : mode_reg;

    // Next state for the byte itself
    always_comb
    begin
        proc_mode   = mode_reg;
        proc_qd     = qd_reg;
        proc_edc    = edc_reg;
        proc_begin  = begin_reg;
        proc_cnt    = cnt_reg;
        close_fire  = 1'b0;
        start_fire  = 1'b0;
        str_fire    = 1'b0;
        hexerr_fire = 1'b0;
        if (byte_live)
        begin
            unique case (eff_mode)
                MODE_IDLE:
                begin
                    start_fire = 1'b1;
                end
                MODE_SPACE:
                begin
                    if (is_space(char_byte)) proc_cnt = cnt_bump;
                    else
                    begin
                        close_fire = 1'b1;
                        start_fire = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_id_cont(char_byte)) proc_cnt = cnt_bump;
                    else
                    begin
                        close_fire = 1'b1;
                        start_fire = 1'b1;
                    end
                end
                MODE_NUM_INT:
                begin
                    if (is_digit(char_byte)) proc_cnt = cnt_bump;
                    else if (char_byte == CH_DOT)
                    begin
                        proc_cnt  = cnt_bump;
                        proc_mode = MODE_NUM_FRAC;
                    end
                    else
                    begin
                        close_fire = 1'b1;
                        start_fire = 1'b1;
                    end
                end
                MODE_NUM_FRAC:
                begin
                    if (is_digit(char_byte)) proc_cnt = cnt_bump;
                    else
                    begin
                        close_fire = 1'b1;
                        start_fire = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    proc_cnt  = cnt_bump;
                    proc_edc  = 1'b0;
                    proc_mode = MODE_STR;
                    if (char_byte == quote_ch)
                    begin
                        str_fire  = 1'b1;
                        proc_mode = MODE_IDLE;
                    end
                    else if (char_byte == CH_BACKSLASH)
                        proc_mode = MODE_ESC;
                end
                MODE_ESC:
                begin
                    proc_cnt = cnt_bump;
                    if (char_byte == CH_X)
                    begin
                        proc_mode = MODE_HEX;
                        proc_edc  = 1'b0;
                    end
                    else
                        proc_mode = MODE_STR;
                end
                MODE_HEX:
                begin
                    if (is_hex(char_byte))
                    begin
                        proc_cnt = cnt_bump;
                        if (edc_reg)
                        begin
                            proc_mode = MODE_STR;
                            proc_edc  = 1'b0;
                        end
                        else
                            proc_edc = 1'b1;
                    end
                    else
                    begin
                        hexerr_fire = 1'b1;
                        proc_mode   = MODE_DISCARD;
                    end
                end
                default:
                begin
                    proc_mode = mode_reg;
                end
            endcase

            if (start_fire)
            begin
                proc_begin = pos_reg;
                proc_cnt   = TOK_W'(1);
                priority if (is_space(char_byte))    proc_mode = MODE_SPACE;
                else if (is_id_start(char_byte))     proc_mode = MODE_IDENT;
                else if (is_digit(char_byte))        proc_mode = MODE_NUM_INT;
                else if (char_byte == CH_DOT)        proc_mode = MODE_NUM_FRAC;
                else if (char_byte == CH_DQUOTE || char_byte == CH_SQUOTE)
                begin
                    proc_mode = MODE_STR;
                    proc_qd   = (char_byte == CH_DQUOTE);
                end
                else                                 proc_mode = MODE_IDLE;
            end
        end
    end

    // Next state including stream end; hold everything unless a byte is taken
    always_comb
    begin
        mode_next  = mode_reg;
        qd_next    = qd_reg;
        edc_next   = edc_reg;
        begin_next = begin_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            if (end_now)
            begin
                mode_next  = MODE_IDLE;
                qd_next    = 1'b0;
                edc_next   = 1'b0;
                begin_next = '0;
                cnt_next   = '0;
                pos_next   = '0;
            end
            else
            begin
                mode_next  = proc_mode;
                qd_next    = proc_qd;
                edc_next   = proc_edc;
                begin_next = proc_begin;
                cnt_next   = proc_cnt;
                pos_next   = byte_live ? pos_inc : pos_reg;
            end
        end
    end

    // Result candidates and selection of the first two
    always_comb
    begin
        res_a = '{kind: KIND_SPACE, start: TOK_W'(begin_reg), length: cnt_reg,
                  err: ERR_NONE, run_last: 1'b0, done: 1'b0};
        va    = close_fire && (mode_reg != MODE_SPACE || !skip_reg);
        unique case (mode_reg)
            MODE_IDENT:                 res_a.kind = KIND_IDENT;
            MODE_NUM_INT, MODE_NUM_FRAC: res_a.kind = KIND_NUMBER;
            default:                    res_a.kind = KIND_SPACE;
        endcase

        res_b = '{kind: KIND_OTHER, start: TOK_W'(pos_reg), length: TOK_W'(1),
                  err: ERR_NONE, run_last: 1'b0, done: 1'b0};
        vb    = 1'b0;
        priority if (str_fire)
        begin
            vb           = 1'b1;
            res_b.kind   = KIND_STRING;
            res_b.start  = TOK_W'(begin_reg);
            res_b.length = cnt_bump;
        end
        else if (hexerr_fire)
        begin
            vb           = 1'b1;
            res_b.kind   = KIND_ERROR;
            res_b.length = '0;
            res_b.err    = ERR_HEX_EMPTY;
            res_b.done   = 1'b1;
        end
        else if (start_fire && proc_mode == MODE_IDLE)
        begin
            vb         = 1'b1;
            res_b.kind = is_punct(char_byte) ? KIND_PUNCT : KIND_OTHER;
        end

        res_c = '{kind: KIND_ERROR, start: TOK_W'(proc_begin), length: proc_cnt,
                  err: ERR_NONE, run_last: 1'b0, done: 1'b1};
        vc    = 1'b0;
        if (end_now)
        begin
            unique case (proc_mode)
                MODE_STR:
                begin
                    vc        = 1'b1;
                    res_c.err = ERR_UNCLOSED;
                end
                MODE_ESC:
                begin
                    vc          = 1'b1;
                    res_c.start = TOK_W'(end_pos);
                    res_c.err   = ERR_ESC_END;
                end
                MODE_HEX:
                begin
                    vc = 1'b1;
                    if (proc_edc) res_c.err = ERR_UNCLOSED;
                    else
                    begin
                        res_c.start = TOK_W'(end_pos);
                        res_c.err   = ERR_HEX_EMPTY;
                    end
                end
                MODE_SPACE:
                begin
                    vc         = !skip_reg;
                    res_c.kind = KIND_SPACE;
                end
                MODE_IDENT:
                begin
                    vc         = 1'b1;
                    res_c.kind = KIND_IDENT;
                end
                MODE_NUM_INT, MODE_NUM_FRAC:
                begin
                    vc         = 1'b1;
                    res_c.kind = KIND_NUMBER;
                end
                default:
                begin
                    vc = 1'b0;
                end
            endcase
            if (res_c.kind == KIND_ERROR) res_c.length = '0;
        end

        // Keep the first two candidates in order
        priority if (va)
        begin
            out0 = res_a;
            out1 = vb ? res_b : res_c;
            v1   = vb || vc;
        end
        else if (vb)
        begin
            out0 = res_b;
            out1 = res_c;
            v1   = vc;
        end
        else
        begin
            out0 = res_c;
            out1 = res_c;
            v1   = 1'b0;
        end
        v0 = va || vb || vc;

        // Flag the last result of this byte; at stream end, or on an error token, it also closes the stream
        out0.run_last = !v1;
        out1.run_last = 1'b1;
        out0.done     = out0.done || (end_now && !v1);
        out1.done     = out1.done || end_now;
        out1.done     = out1.done || (out1.kind == KIND_ERROR);
    end

    assign n_push = accept ? ({1'b0, v0} + {1'b0, v1}) : 2'd0;
    assign pop    = out_valid && out_ready;

    // Lexer and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            qd_reg    <= 1'b0;
            edc_reg   <= 1'b0;
            begin_reg <= '0;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            qd_reg    <= qd_next;
            edc_reg   <= edc_next;
            begin_reg <= begin_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            if (cfg_valid && cfg_ready) skip_reg <= skip_space;
        end
    end

    // Result queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(n_push);
            if (pop) rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(1);
            q_cnt_reg  <= q_cnt_reg + RES_CNT_W'(n_push) - RES_CNT_W'(pop);
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (accept && v0) q_mem_reg[wr_ptr_reg] <= out0;
        if (accept && v1) q_mem_reg[wr_ptr_reg + RES_PTR_W'(1)] <= out1;
    end

    assign out_valid    = (q_cnt_reg != '0);
    assign token_kind   = q_mem_reg[rd_ptr_reg].kind;
    assign token_start  = q_mem_reg[rd_ptr_reg].start;
    assign token_length = q_mem_reg[rd_ptr_reg].length;
    assign error_code   = q_mem_reg[rd_ptr_reg].err;
    assign run_last     = q_mem_reg[rd_ptr_reg].run_last;
    assign stream_done  = q_mem_reg[rd_ptr_reg].done;

endmodule

>>> rtl/pet_checker.sv
// Port-level checks for the path expression tokenizer, with its bind.
// Depends on pet_pkg for token kinds and error codes.
module pet_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [2:0]                token_kind,
    input logic [pet_pkg::TOK_W-1:0] token_length,
    input logic [1:0]                error_code,
    input logic                      run_last,
    input logic                      stream_done
);
    import pet_pkg::*;

    // A stalled token stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("token dropped while stalled");

    // Error tokens carry a code, no length, and end the stream
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_ERROR |->
            token_length == '0 && error_code != ERR_NONE && stream_done)
        else $error("malformed error token");

    // Ordinary tokens carry no error code
    a_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != KIND_ERROR |-> error_code == ERR_NONE)
        else $error("error code on ordinary token");

    // The stream closes on the last token of a byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_done |-> run_last)
        else $error("stream end before last token of byte");

endmodule

bind path_expression_tokenizer pet_checker u_pet_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_length (token_length),
    .error_code   (error_code),
    .run_last     (run_last),
    .stream_done  (stream_done)
);
